@@ sv/assert_macros.svh @@
// Assertion helpers used by the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked check, disabled while reset is asserted.
`define ASSERT_CLK(label, prop, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (prop)) else $error(msg);

// Plain implication check, same clocking and reset.
`define ASSERT_IMPL(label, cond, prop, msg) \
    `ASSERT_CLK(label, (cond) |-> (prop), msg)

`endif

@@ sv/lkv_pkg.sv @@
package lkv_pkg;

    // operation codes
    localparam logic KIND_GET = 1'b0;
    localparam logic KIND_PUT = 1'b1;

    // capacity register
    localparam int CAP_BITS = 5;
    localparam logic [CAP_BITS-1:0] CAP_RESET = 5'd16;

    // per-entry update command
    typedef struct packed {
        logic sel;        // this entry is the target of the request
        logic wr_key;     // target takes the new key (insert or replace)
        logic wr_value;   // target takes the new value
        logic age_all;    // every other valid entry ages by one
        logic age_lower;  // entries younger than the reference rank age by one
    } t_cell_cmd;

endpackage

@@ sv/lkv_cell.sv @@
module lkv_cell #(
    parameter int KEY_BITS   = 16,
    parameter int VALUE_BITS = 32,
    parameter int RANK_W     = 4
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_fire,
    input  lkv_pkg::t_cell_cmd    i_cmd,
    input  logic [KEY_BITS-1:0]   i_key,
    input  logic [VALUE_BITS-1:0] i_value,
    input  logic [RANK_W-1:0]     i_ref_rank,
    input  logic [RANK_W-1:0]     i_last_rank,
    output logic                  o_valid,
    output logic                  o_match,
    output logic                  o_victim,
    output logic [RANK_W-1:0]     o_rank,
    output logic [KEY_BITS-1:0]   o_key,
    output logic [VALUE_BITS-1:0] o_value
);
    import lkv_pkg::*;

    logic                  r_valid;
    logic                  n_valid;
    logic [RANK_W-1:0]     r_rank;
    logic [RANK_W-1:0]     n_rank;
    logic [KEY_BITS-1:0]   r_key;
    logic [VALUE_BITS-1:0] r_value;

    // lookup and victim match at this entry
    assign o_valid  = r_valid;
    assign o_match  = r_valid && (r_key == i_key);
    assign o_victim = r_valid && (r_rank == i_last_rank);
    assign o_rank   = r_rank;
    assign o_key    = r_key;
    assign o_value  = r_value;

    // recency update
    always_comb begin
        n_valid = r_valid;
        n_rank  = r_rank;
        if (i_fire) begin
            if (i_cmd.sel) begin
                n_rank = '0;
                if (i_cmd.wr_key) begin
                    n_valid = 1'b1;
                end
            end else if (r_valid) begin
                if (i_cmd.age_all || (i_cmd.age_lower && (r_rank < i_ref_rank))) begin
                    n_rank = r_rank + RANK_W'(1);
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_rank  <= '0;
        end else begin
            r_valid <= n_valid;
            r_rank  <= n_rank;
        end
    end

    // key and value storage, no reset
    always_ff @(posedge i_clk) begin
        if (i_fire && i_cmd.sel) begin
            if (i_cmd.wr_key) begin
                r_key <= i_key;
            end
            if (i_cmd.wr_value) begin
                r_value <= i_value;
            end
        end
    end

endmodule

@@ sv/lru_key_value_cache.sv @@
// Fully associative key-value cache with least-recently-used replacement.
// Input channel (i_in_valid / o_in_stall): one request per accept, i_kind
// selects get or put of i_key, i_value is the data stored by a put.
// Output channel (o_out_valid / i_out_stall): one result per request, in
// request order: o_hit, o_read_value (get hit only, else zero), o_evicted
// and o_evicted_key (put of a new key into a full cache, else zero).
// Config channel (i_cfg_valid / o_cfg_ready): writes the capacity; zero
// acts as one, values above ENTRIES act as ENTRIES. Write only when idle.
// A request passes through the input register, then the result register;
// the result is valid once it has been written to the result register.
// Throughput: one request per cycle while the receiver does not stall; all
// entries are compared in parallel and the affected entries update their ranks in the same cycle.
// Reset clears every valid mark and rank, the entry count and the valid flags
// of both pipeline registers; capacity returns to 16. Nothing else needs clearing.
// When the receiver stalls, the result holds and the input register keeps
// its request; o_in_stall rises only when both registers are occupied.
module lru_key_value_cache #(
    parameter int ENTRIES    = 16,
    parameter int KEY_BITS   = 16,
    parameter int VALUE_BITS = 32
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    // request channel
    input  logic                          i_in_valid,
    output logic                          o_in_stall,
    input  logic                          i_kind,
    input  logic [KEY_BITS-1:0]           i_key,
    input  logic signed [VALUE_BITS-1:0]  i_value,
    // result channel
    output logic                          o_out_valid,
    input  logic                          i_out_stall,
    output logic                          o_hit,
    output logic signed [VALUE_BITS-1:0]  o_read_value,
    output logic                          o_evicted,
    output logic [KEY_BITS-1:0]           o_evicted_key,
    // capacity write channel
    input  logic                          i_cfg_valid,
    output logic                          o_cfg_ready,
    input  logic [lkv_pkg::CAP_BITS-1:0]  i_cfg_data
);
    import lkv_pkg::*;

    localparam int RANK_W = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam int CNT_W  = $clog2(ENTRIES + 1);
    localparam int CMP_W  = (CNT_W > CAP_BITS) ? CNT_W : CAP_BITS;

    // input register
    logic                  r_in_valid;
    logic                  r_in_kind;
    logic [KEY_BITS-1:0]   r_in_key;
    logic [VALUE_BITS-1:0] r_in_value;

    // result register
    logic                  r_out_valid;
    logic                  r_out_hit;
    logic [VALUE_BITS-1:0] r_out_read_value;
    logic                  r_out_evicted;
    logic [KEY_BITS-1:0]   r_out_evicted_key;

    logic [CAP_BITS-1:0]   r_cap;
    logic [CNT_W-1:0]      r_count;
    logic [CNT_W-1:0]      n_count;
    logic [CNT_W-1:0]      w_count_p1;

    logic w_adv;
    logic w_take;

    // per-entry signals
    logic [ENTRIES-1:0]    w_valid;
    logic [ENTRIES-1:0]    w_match;
    logic [ENTRIES-1:0]    w_victim;
    logic [ENTRIES-1:0]    w_free;
    logic [ENTRIES-1:0]    w_inv;
    logic [ENTRIES-1:0]    w_target;
    logic [RANK_W-1:0]     w_rank  [ENTRIES];
    logic [KEY_BITS-1:0]   w_key   [ENTRIES];
    logic [VALUE_BITS-1:0] w_value [ENTRIES];
    t_cell_cmd             w_cmd   [ENTRIES];

    logic                  w_hit;
    logic                  w_put;
    logic                  w_room;
    logic                  w_insert;
    logic                  w_evict;
    logic [RANK_W-1:0]     w_hit_rank;
    logic [RANK_W-1:0]     w_last_rank;
    logic [VALUE_BITS-1:0] w_hit_value;
    logic [KEY_BITS-1:0]   w_vict_key;
    logic [CMP_W-1:0]      w_cap_eff;
    logic [CNT_W-1:0]      w_count_m1;

    // handshake
    assign w_adv       = r_in_valid && (!r_out_valid || !i_out_stall);
    assign o_in_stall  = r_in_valid && !w_adv;
    assign w_take      = i_in_valid && !o_in_stall;
    assign o_cfg_ready = 1'b1;

    // effective capacity
    always_comb begin
        w_cap_eff = CMP_W'(r_cap);
        if (r_cap == '0) begin
            w_cap_eff = CMP_W'(1);
        end else if (CMP_W'(r_cap) > CMP_W'(ENTRIES)) begin
            w_cap_eff = CMP_W'(ENTRIES);
        end
    end

    assign w_count_m1  = r_count - CNT_W'(1);
    assign w_last_rank = w_count_m1[RANK_W-1:0];

    // first free entry
    assign w_inv  = ~w_valid;
    assign w_free = w_inv & (~w_inv + ENTRIES'(1));

    // lookup reductions
    always_comb begin
        w_hit_rank  = '0;
        w_hit_value = '0;
        w_vict_key  = '0;
        for (int i = 0; i < ENTRIES; i++) begin
            w_hit_rank  = w_hit_rank  | (w_rank[i]  & {RANK_W{w_match[i]}});
            w_hit_value = w_hit_value | (w_value[i] & {VALUE_BITS{w_match[i]}});
            w_vict_key  = w_vict_key  | (w_key[i]   & {KEY_BITS{w_victim[i]}});
        end
    end

    // request decode
    assign w_hit    = |w_match;
    assign w_put    = (r_in_kind == KIND_PUT);
    assign w_room   = CMP_W'(r_count) < w_cap_eff;
    assign w_insert = w_put && !w_hit && w_room;
    assign w_evict  = w_put && !w_hit && !w_room && (r_count != '0);

    always_comb begin
        if (w_hit) begin
            w_target = w_match;
        end else if (w_insert) begin
            w_target = w_free;
        end else if (w_evict) begin
            w_target = w_victim;
        end else begin
            w_target = '0;
        end
    end

    // entry commands
    always_comb begin
        for (int i = 0; i < ENTRIES; i++) begin
            w_cmd[i].sel       = w_target[i];
            w_cmd[i].wr_key    = w_insert || w_evict;
            w_cmd[i].wr_value  = w_put;
            w_cmd[i].age_all   = w_insert || w_evict;
            w_cmd[i].age_lower = w_hit;
        end
    end

    // entry array
    for (genvar g = 0; g < ENTRIES; g++) begin : g_cell
        lkv_cell #(
            .KEY_BITS   (KEY_BITS),
            .VALUE_BITS (VALUE_BITS),
            .RANK_W     (RANK_W)
        ) u_cell (
            .i_clk       (i_clk),
            .i_rst_n     (i_rst_n),
            .i_fire      (w_adv),
            .i_cmd       (w_cmd[g]),
            .i_key       (r_in_key),
            .i_value     (r_in_value),
            .i_ref_rank  (w_hit_rank),
            .i_last_rank (w_last_rank),
            .o_valid     (w_valid[g]),
            .o_match     (w_match[g]),
            .o_victim    (w_victim[g]),
            .o_rank      (w_rank[g]),
            .o_key       (w_key[g]),
            .o_value     (w_value[g])
        );
    end

    assign w_count_p1 = r_count + CNT_W'(1);
    assign n_count    = (w_adv && w_insert) ? w_count_p1 : r_count;

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_count     <= '0;
            r_cap       <= CAP_RESET;
        end else begin
            if (w_take) begin
                r_in_valid <= 1'b1;
            end else if (w_adv) begin
                r_in_valid <= 1'b0;
            end
            if (w_adv) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
            r_count <= n_count;
            if (i_cfg_valid && o_cfg_ready) begin
                r_cap <= i_cfg_data;
            end
        end
    end

    // request payload
    always_ff @(posedge i_clk) begin
        if (w_take) begin
            r_in_kind  <= i_kind;
            r_in_key   <= i_key;
            r_in_value <= i_value;
        end
    end

    // result payload
    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_out_hit         <= w_hit;
            r_out_read_value  <= (w_hit && !w_put) ? w_hit_value : '0;
            r_out_evicted     <= w_evict;
            r_out_evicted_key <= w_evict ? w_vict_key : '0;
        end
    end

    assign o_out_valid   = r_out_valid;
    assign o_hit         = r_out_hit;
    assign o_read_value  = r_out_read_value;
    assign o_evicted     = r_out_evicted;
    assign o_evicted_key = r_out_evicted_key;

    // checks
    `include "assert_macros.svh"

    `ASSERT_CLK(a_unique_key, $onehot0(w_match), "more than one entry holds the key")
    `ASSERT_CLK(a_count_valid, $countones(w_valid) == int'(r_count), "entry count mismatch")
    `ASSERT_CLK(a_insert_count, w_adv && w_insert |=> r_count == $past(w_count_p1), "bad count")
    `ASSERT_IMPL(a_hit_no_evict, o_out_valid && o_hit, !o_evicted, "hit reported an eviction")

endmodule

@@ sim/tb_lru_key_value_cache.sv @@
`timescale 1ns / 1ps

module tb_lru_key_value_cache;
    import lkv_pkg::*;

    localparam int ENTRIES = 16;

    typedef struct packed {
        logic        kind;
        logic [15:0] key;
        logic [31:0] value;
    } t_cache_req;

    typedef struct packed {
        logic        hit;
        logic [31:0] read_value;
        logic        evicted;
        logic [15:0] evicted_key;
    } t_lookup_result;

    // clock, reset and DUT inputs, all known from time zero
    logic                i_clk = 1'b0;
    logic                i_rst_n = 1'b0;
    logic                i_in_valid = 1'b0;
    logic                i_kind = KIND_GET;
    logic [15:0]         i_key = '0;
    logic signed [31:0]  i_value = '0;
    logic                i_out_stall = 1'b0;
    logic                i_cfg_valid = 1'b0;
    logic [CAP_BITS-1:0] i_cfg_data = '0;

    logic                o_in_stall;
    logic                o_out_valid;
    logic                o_hit;
    logic signed [31:0]  o_read_value;
    logic                o_evicted;
    logic [15:0]         o_evicted_key;
    logic                o_cfg_ready;

    // shadow copy of the cache contents
    logic                line_valid [ENTRIES];
    logic [15:0]         line_key   [ENTRIES];
    logic [31:0]         line_value [ENTRIES];
    int                  line_rank  [ENTRIES];
    int                  line_count = 0;
    logic [CAP_BITS-1:0] cache_capacity = CAP_RESET;

    t_cache_req          request_queue [$];
    t_lookup_result      expected_lookups [$];
    t_cache_req          next_req;
    t_lookup_result      exp_res;
    logic                req_taken = 1'b0;
    int                  send_idle_pct = 0;
    int                  recv_idle_pct = 0;
    int                  error_count = 0;

    lru_key_value_cache dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (i_in_valid),
        .o_in_stall    (o_in_stall),
        .i_kind        (i_kind),
        .i_key         (i_key),
        .i_value       (i_value),
        .o_out_valid   (o_out_valid),
        .i_out_stall   (i_out_stall),
        .o_hit         (o_hit),
        .o_read_value  (o_read_value),
        .o_evicted     (o_evicted),
        .o_evicted_key (o_evicted_key),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_data    (i_cfg_data)
    );

    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    initial begin
        for (int i = 0; i < ENTRIES; i++) begin
            line_valid[i] = 1'b0;
            line_key[i]   = '0;
            line_value[i] = '0;
            line_rank[i]  = 0;
        end
    end

    // zero acts as one, anything above the entry count as the entry count
    function automatic int effective_capacity(logic [CAP_BITS-1:0] cap);
        if (cap == 0)
            return 1;
        if (cap > ENTRIES)
            return ENTRIES;
        return int'(cap);
    endfunction

    // make slot s the most recent; younger valid entries age by one
    function automatic void promote(int s, int old_rank);
        for (int i = 0; i < ENTRIES; i++)
            if (line_valid[i] && i != s && line_rank[i] < old_rank)
                line_rank[i]++;
        line_rank[s] = 0;
    endfunction

    // apply one request to the shadow cache and return its result
    function automatic t_lookup_result cache_access(t_cache_req req);
        t_lookup_result res;
        int slot;
        res  = '0;
        slot = -1;
        for (int i = 0; i < ENTRIES; i++)
            if (slot < 0 && line_valid[i] && line_key[i] == req.key)
                slot = i;
        if (slot >= 0) begin
            res.hit = 1'b1;
            if (req.kind == KIND_GET)
                res.read_value = line_value[slot];
            else
                line_value[slot] = req.value;
            promote(slot, line_rank[slot]);
        end else if (req.kind == KIND_PUT) begin
            if (line_count < effective_capacity(cache_capacity))
                for (int i = 0; i < ENTRIES; i++)
                    if (slot < 0 && !line_valid[i])
                        slot = i;
            if (slot >= 0) begin
                line_valid[slot] = 1'b1;
                line_key[slot]   = req.key;
                line_value[slot] = req.value;
                line_rank[slot]  = 0;
                promote(slot, ENTRIES);
                line_count++;
            end else begin
                // victim is the valid entry with the largest rank
                for (int i = 0; i < ENTRIES; i++)
                    if (line_valid[i] && (slot < 0 || line_rank[i] > line_rank[slot]))
                        slot = i;
                if (slot >= 0) begin
                    res.evicted      = 1'b1;
                    res.evicted_key  = line_key[slot];
                    line_key[slot]   = req.key;
                    line_value[slot] = req.value;
                    promote(slot, line_rank[slot]);
                end
            end
        end
        return res;
    endfunction

    task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
        $display("%0t: mismatch on %s: got %h, expected %h", $realtime, what, got, want);
        error_count++;
    endtask

    // request driver: changes on the falling edge, holds while not taken
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            i_in_valid  <= 1'b0;
            i_out_stall <= 1'b0;
        end else begin
            if (!i_in_valid || req_taken) begin
                if (request_queue.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
                    next_req = request_queue.pop_front();
                    i_in_valid <= 1'b1;
                    i_kind     <= next_req.kind;
                    i_key      <= next_req.key;
                    i_value    <= next_req.value;
                end else begin
                    i_in_valid <= 1'b0;
                end
            end
            i_out_stall <= ($urandom_range(99) < recv_idle_pct);
        end
    end

    // monitor: predicts on each accepted request, checks each accepted result
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            req_taken <= 1'b0;
        end else begin
            req_taken <= i_in_valid && !o_in_stall;
            if (i_in_valid && !o_in_stall)
                expected_lookups.push_back(cache_access({i_kind, i_key, i_value}));
            if (o_out_valid && !i_out_stall) begin
                if (expected_lookups.size() == 0) begin
                    report_mismatch("unexpected result", {o_evicted_key, 15'd0, o_hit}, '0);
                end else begin
                    exp_res = expected_lookups.pop_front();
                    if (o_hit !== exp_res.hit)
                        report_mismatch("hit", 32'(o_hit), 32'(exp_res.hit));
                    if (o_read_value !== exp_res.read_value)
                        report_mismatch("read_value", o_read_value, exp_res.read_value);
                    if (o_evicted !== exp_res.evicted)
                        report_mismatch("evicted", 32'(o_evicted), 32'(exp_res.evicted));
                    if (o_evicted_key !== exp_res.evicted_key)
                        report_mismatch("evicted_key", 32'(o_evicted_key),
                                        32'(exp_res.evicted_key));
                end
            end
        end
    end

    task automatic queue_request(logic kind, logic [15:0] key, logic [31:0] value);
        request_queue.push_back({kind, key, value});
    endtask

    // wait until every request is sent and every result is back
    task automatic wait_drained();
        while (request_queue.size() != 0 || i_in_valid || expected_lookups.size() != 0)
            @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic set_capacity(logic [CAP_BITS-1:0] cap);
        wait_drained();
        @(negedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= cap;
        do @(posedge i_clk); while (!o_cfg_ready);
        cache_capacity = cap;
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    // random traffic over a small key pool so hits and evictions are common
    task automatic queue_random_traffic(int count);
        logic [15:0] key_pool [$];
        int pool_n;
        logic [15:0] key;
        pool_n = effective_capacity(cache_capacity) + $urandom_range(1, 6);
        for (int i = 0; i < pool_n; i++)
            key_pool.push_back(16'($urandom));
        for (int i = 0; i < count; i++) begin
            if ($urandom_range(9) == 0)
                key = 16'($urandom);
            else
                key = key_pool[$urandom_range(pool_n - 1)];
            queue_request(($urandom_range(99) < 45) ? KIND_PUT : KIND_GET, key, $urandom);
        end
    endtask

    initial begin
        logic [CAP_BITS-1:0] cap_plan [10];
        cap_plan = '{5'd16, 5'd1, 5'd0, 5'd31, 5'd4, 5'd17, 5'd2, 5'd9, 5'd16, 5'd3};

        repeat (11) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        send_idle_pct = 18;
        recv_idle_pct = 53;

        // directed: misses on empty cache, extreme keys and values, put hit
        queue_request(KIND_GET, 16'h0000, 32'h0);
        queue_request(KIND_GET, 16'hFFFF, 32'hFFFF_FFFF);
        queue_request(KIND_PUT, 16'h0000, 32'h8000_0000);
        queue_request(KIND_PUT, 16'hFFFF, 32'h7FFF_FFFF);
        queue_request(KIND_GET, 16'h0000, 32'h0);
        queue_request(KIND_GET, 16'hFFFF, 32'h0);
        queue_request(KIND_PUT, 16'h0000, 32'hFFFF_FFFF);
        queue_request(KIND_GET, 16'h0000, 32'h1234_5678);
        queue_request(KIND_PUT, 16'h5AA5, 32'h0);

        // capacity below the held count: new keys evict, count stays
        set_capacity(5'd1);
        queue_request(KIND_PUT, 16'h1234, 32'h1);
        queue_request(KIND_GET, 16'hFFFF, 32'h0);
        queue_request(KIND_PUT, 16'h1234, 32'h7);
        queue_request(KIND_PUT, 16'h4321, 32'hDEAD_BEEF);

        // zero capacity acts as one
        set_capacity(5'd0);
        queue_request(KIND_PUT, 16'hA5A5, 32'h5555_AAAA);
        queue_request(KIND_GET, 16'h0000, 32'h0);
        queue_request(KIND_GET, 16'h4321, 32'h0);

        // capacity above the entry count: free slots fill again
        set_capacity(5'd31);
        queue_request(KIND_PUT, 16'h0F0F, 32'hAAAA_5555);
        queue_request(KIND_PUT, 16'hF0F0, 32'h0000_0001);
        queue_request(KIND_GET, 16'hA5A5, 32'h0);
        queue_request(KIND_GET, 16'h0F0F, 32'h0);

        // random phases over several capacities and idling modes
        for (int seg = 0; seg < 10; seg++) begin
            set_capacity(cap_plan[seg]);
            if (seg < 4) begin
                send_idle_pct = 18;
                recv_idle_pct = 53;
            end else if (seg < 8) begin
                send_idle_pct = 53;
                recv_idle_pct = 18;
            end else begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
            end
            queue_random_traffic(185);
        end

        wait_drained();
        repeat (10) @(posedge i_clk);
        if (error_count == 0 && expected_lookups.size() == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

    // watchdog
    initial begin
        #2_000_000;
        $display("*** FAILED ***");
        $finish;
    end

endmodule

@@ filelist.f @@
+incdir+sv
sv/lkv_pkg.sv
sv/lkv_cell.sv
sv/lru_key_value_cache.sv
sim/tb_lru_key_value_cache.sv
